/* sv/kdq_pkg.sv */
// ---------------------------------------------------------------------------
// kdq_pkg: shared types and codes for the keyed deque core
// Holds the request and response item formats, operation and status codes,
// the per-cell command format and the scan token that walks the cell row.
// ---------------------------------------------------------------------------
package kdq_pkg;

   // Default number of entries
   localparam int DEPTH_DEF = 16;

   // Operation codes
   localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [3:0] OP_POP_FRONT  = 4'd2;
   localparam logic [3:0] OP_POP_BACK   = 4'd3;
   localparam logic [3:0] OP_PEEK_FRONT = 4'd4;
   localparam logic [3:0] OP_PEEK_BACK  = 4'd5;
   localparam logic [3:0] OP_FIND_KEY   = 4'd6;
   localparam logic [3:0] OP_REMOVE_KEY = 4'd7;
   localparam logic [3:0] OP_FIND_MIN   = 4'd8;
   localparam logic [3:0] OP_REMOVE_MIN = 4'd9;

   // Status codes
   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_NONE = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] key;
      logic [31:0]        payload;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_key;
      logic [31:0]        found_payload;
      logic [4:0]         entry_count;
   } rsp_type;

   // What every cell does with its entry this cycle
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_SHIFT_UP,
      CMD_WRITE_AT,
      CMD_CLOSE_AT
   } cell_cmd_type;

   // Which entry the scan token picks up
   typedef enum logic [1:0] {
      SCAN_FRONT,
      SCAN_BACK,
      SCAN_FIND,
      SCAN_MIN
   } scan_mode_type;

   // Broadcast control from the sequencer to all cells
   typedef struct packed {
      cell_cmd_type       cmd;
      scan_mode_type      mode;
      logic signed [31:0] key;
      logic [31:0]        payload;
   } cell_ctl_type;

   // Scan token handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic signed [31:0] key;
      logic [31:0]        payload;
   } token_type;

   // Operations that need a sweep over the cells
   function automatic logic is_scan_op(input logic [3:0] opcode);
      logic res;
      case (opcode) inside
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK,
         OP_FIND_KEY, OP_REMOVE_KEY, OP_FIND_MIN, OP_REMOVE_MIN: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

   // Operations that take the found entry out
   function automatic logic is_remove_op(input logic [3:0] opcode);
      logic res;
      case (opcode) inside
         OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_KEY, OP_REMOVE_MIN: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

   // Scan selection for a sweep operation
   function automatic scan_mode_type scan_mode(input logic [3:0] opcode);
      scan_mode_type res;
      case (opcode) inside
         OP_POP_FRONT, OP_PEEK_FRONT: res = SCAN_FRONT;
         OP_POP_BACK, OP_PEEK_BACK:   res = SCAN_BACK;
         OP_FIND_KEY, OP_REMOVE_KEY:  res = SCAN_FIND;
         default:                     res = SCAN_MIN;
      endcase
      return res;
   endfunction

endpackage

/* sv/keyed_deque_with_min_extract_core.sv */
// ---------------------------------------------------------------------------
// keyed_deque_with_min_extract_core: bounded deque with key and minimum search
// Holds up to DEPTH key/payload entries in a row of cells, front at cell 0.
//
// Usage: drive req_data and raise start while busy is low; the item is taken
// at that edge and busy rises. Exactly one result item follows on rsp_data,
// marked by a one-cycle rsp_strobe. busy falls in the cycle the strobe is
// high, so the next item may be taken at the edge that ends it.
// Pushes and unused opcodes go through the EXEC state to their result.
// Pops, peeks, key searches and minimum searches send a scan token down the
// cell row, one cell per cycle, and return once it leaves the last cell;
// removal closes the gap in the same edge that registers the result.
// Reset: synchronous, active high; the deque comes out empty (count zero).
// Entry contents are not cleared and need no clearing pass.
// The receiver cannot stall; rsp_data holds each result until the next one.
// ---------------------------------------------------------------------------
module keyed_deque_with_min_extract_core #(
   parameter int DEPTH = kdq_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kdq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output kdq_pkg::rsp_type rsp_data
);
   import kdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      IDLE = 3'b001,
      EXEC = 3'b010,
      SCAN = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               launch_ff, launch_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cell_ctl_type       ctl;
   logic [IDX_W-1:0]   ctl_index;
   logic               full;

   logic signed [31:0] cell_key     [DEPTH];
   logic [31:0]        cell_payload [DEPTH];
   token_type          tok          [DEPTH+1];
   logic [IDX_W-1:0]   tok_pos      [DEPTH+1];

   assign full = (count_ff == CNT_W'(DEPTH));

   // Token enters the row right after a sweep operation is taken
   assign tok[0]     = '{valid: launch_ff, hit: 1'b0, key: '0, payload: '0};
   assign tok_pos[0] = '0;

   // Cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] prev_key, next_key;
      logic [31:0]        prev_payload, next_payload;

      if (i == 0) begin : g_head
         assign prev_key     = req_ff.key;
         assign prev_payload = req_ff.payload;
      end else begin : g_body
         assign prev_key     = cell_key[i-1];
         assign prev_payload = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_key     = cell_key[i];
         assign next_payload = cell_payload[i];
      end else begin : g_inner
         assign next_key     = cell_key[i+1];
         assign next_payload = cell_payload[i+1];
      end

      kdq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .ctl_index    (ctl_index),
         .count        (count_ff),
         .prev_key     (prev_key),
         .prev_payload (prev_payload),
         .next_key     (next_key),
         .next_payload (next_payload),
         .key          (cell_key[i]),
         .payload      (cell_payload[i]),
         .tok_in       (tok[i]),
         .tok_pos_in   (tok_pos[i]),
         .tok_out      (tok[i+1]),
         .tok_pos_out  (tok_pos[i+1])
      );
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      launch_in     = 1'b0;
      count_in      = count_ff;
      ctl.cmd       = CMD_HOLD;
      ctl.mode      = scan_mode(req_ff.opcode);
      ctl.key       = req_ff.key;
      ctl.payload   = req_ff.payload;
      ctl_index     = '0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               req_in = req_data;
               if (is_scan_op(req_data.opcode)) begin
                  state_in  = SCAN;
                  launch_in = 1'b1;
               end else begin
                  state_in = EXEC;
               end
            end
         end
         EXEC: begin
            state_in      = IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in.status = STS_OK;
            if (req_ff.opcode == OP_PUSH_FRONT || req_ff.opcode == OP_PUSH_BACK) begin
               if (full) begin
                  rsp_in.status = STS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (req_ff.opcode == OP_PUSH_FRONT) begin
                     ctl.cmd = CMD_SHIFT_UP;
                  end else begin
                     ctl.cmd   = CMD_WRITE_AT;
                     ctl_index = IDX_W'(count_ff);
                  end
               end
            end
            rsp_in.found_key     = '0;
            rsp_in.found_payload = '0;
            rsp_in.entry_count   = 5'(count_in);
         end
         SCAN: begin
            if (tok[DEPTH].valid) begin
               state_in      = IDLE;
               rsp_strobe_in = 1'b1;
               if (tok[DEPTH].hit) begin
                  rsp_in.status        = STS_OK;
                  rsp_in.found_key     = tok[DEPTH].key;
                  rsp_in.found_payload = tok[DEPTH].payload;
                  if (is_remove_op(req_ff.opcode)) begin
                     ctl.cmd   = CMD_CLOSE_AT;
                     ctl_index = tok_pos[DEPTH];
                     count_in  = count_ff - 1'b1;
                  end
               end else begin
                  rsp_in.status        = STS_NONE;
                  rsp_in.found_key     = '0;
                  rsp_in.found_payload = '0;
               end
               rsp_in.entry_count = 5'(count_in);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_strobe_ff <= 1'b0;
         launch_ff     <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         launch_ff     <= launch_in;
         count_ff      <= count_in;
      end
   end

   // Item registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[DEPTH].valid |-> (state_ff == SCAN))
      else $error("scan token left the row outside a sweep");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STS_FULL) |-> full)
      else $error("full status while store not full");
`endif

endmodule

/* sv/kdq_cell.sv */
// ---------------------------------------------------------------------------
// kdq_cell: one entry slot of the keyed deque
// Holds one key and payload, moves them to or from its neighbors on a
// broadcast command, and updates the scan token as it passes by.
// ---------------------------------------------------------------------------
module kdq_cell #(
   parameter int DEPTH = kdq_pkg::DEPTH_DEF,
   parameter int INDEX = 0,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kdq_pkg::cell_ctl_type  ctl,
   input  logic [IDX_W-1:0]       ctl_index,
   input  logic [CNT_W-1:0]       count,
   input  logic signed [31:0]     prev_key,
   input  logic [31:0]            prev_payload,
   input  logic signed [31:0]     next_key,
   input  logic [31:0]            next_payload,
   output logic signed [31:0]     key,
   output logic [31:0]            payload,
   input  kdq_pkg::token_type     tok_in,
   input  logic [IDX_W-1:0]       tok_pos_in,
   output kdq_pkg::token_type     tok_out,
   output logic [IDX_W-1:0]       tok_pos_out
);
   import kdq_pkg::*;

   logic signed [31:0] key_ff, key_in;
   logic [31:0]        payload_ff, payload_in;
   token_type          tok_ff, tok_in_next;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               occupied;
   logic               is_last;
   logic               take;

   // Entry movement
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      case (ctl.cmd)
         CMD_SHIFT_UP: begin
            key_in     = prev_key;
            payload_in = prev_payload;
         end
         CMD_WRITE_AT: begin
            if (ctl_index == IDX_W'(INDEX)) begin
               key_in     = ctl.key;
               payload_in = ctl.payload;
            end
         end
         CMD_CLOSE_AT: begin
            if (IDX_W'(INDEX) >= ctl_index) begin
               key_in     = next_key;
               payload_in = next_payload;
            end
         end
         default: begin
         end
      endcase
   end

   // Decide whether this slot replaces the token's pick
   assign occupied = (CNT_W'(INDEX) < count);
   assign is_last  = (CNT_W'(INDEX + 1) == count);

   always_comb begin
      case (ctl.mode)
         SCAN_FRONT: take = occupied && (INDEX == 0);
         SCAN_BACK:  take = occupied && is_last;
         SCAN_FIND:  take = occupied && !tok_in.hit && (key_ff == ctl.key);
         default:    take = occupied && (!tok_in.hit || (key_ff < tok_in.key));
      endcase
   end

   always_comb begin
      tok_in_next = tok_in;
      pos_in      = tok_pos_in;
      if (tok_in.valid && take) begin
         tok_in_next.hit     = 1'b1;
         tok_in_next.key     = key_ff;
         tok_in_next.payload = payload_ff;
         pos_in              = IDX_W'(INDEX);
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      pos_ff     <= pos_in;
   end

   // Advance the token one slot
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign key         = key_ff;
   assign payload     = payload_ff;
   assign tok_out     = tok_ff;
   assign tok_pos_out = pos_ff;

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the keyed deque core
// Feeds push, pop, peek, key search and minimum search items through the
// start/busy port with random idle gaps. Each taken item is applied to a
// behavioral deque kept here, and every strobed response is compared field by
// field with the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kdq_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int ITEM_TARGET = 1700;

   // One queued operation with the idle cycles that go before it
   typedef struct {
      req_type     req;
      int unsigned gap;
      bit          drain;
   } op_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   op_slot_type        op_slots[$];
   rsp_type            expected_rsp[$];
   logic signed [31:0] deque_keys[$];
   logic [31:0]        deque_payloads[$];
   int                 outstanding = 0;
   int unsigned        idle_cycles = 0;
   int                 error_count = 0;

   keyed_deque_with_min_extract_core #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // Free-running clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Hold reset for the first cycles only
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Abort a hung run
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Apply one item to the behavioral deque and return its response
   function automatic rsp_type apply_op(input req_type r);
      rsp_type res;
      logic    hit;
      logic    drop;
      int      pos;
      res        = '0;
      res.status = STS_OK;
      hit        = 1'b0;
      drop       = 1'b0;
      pos        = 0;
      case (r.opcode) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (deque_keys.size() >= DEPTH) begin
               res.status = STS_FULL;
            end else if (r.opcode == OP_PUSH_FRONT) begin
               deque_keys.push_front(r.key);
               deque_payloads.push_front(r.payload);
            end else begin
               deque_keys.push_back(r.key);
               deque_payloads.push_back(r.payload);
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (deque_keys.size() > 0) begin
               hit = 1'b1;
               if (r.opcode == OP_POP_BACK || r.opcode == OP_PEEK_BACK)
                  pos = deque_keys.size() - 1;
            end
            drop = (r.opcode == OP_POP_FRONT || r.opcode == OP_POP_BACK);
         end
         OP_FIND_KEY, OP_REMOVE_KEY: begin
            for (int i = 0; i < deque_keys.size(); i++) begin
               if (!hit && deque_keys[i] == r.key) begin
                  hit = 1'b1;
                  pos = i;
               end
            end
            drop = (r.opcode == OP_REMOVE_KEY);
         end
         OP_FIND_MIN, OP_REMOVE_MIN: begin
            // front-most smallest key wins on ties
            if (deque_keys.size() > 0) begin
               hit = 1'b1;
               for (int i = 1; i < deque_keys.size(); i++)
                  if (deque_keys[i] < deque_keys[pos])
                     pos = i;
            end
            drop = (r.opcode == OP_REMOVE_MIN);
         end
         default: begin
         end
      endcase
      if (r.opcode >= OP_POP_FRONT && r.opcode <= OP_REMOVE_MIN) begin
         if (hit) begin
            res.found_key     = deque_keys[pos];
            res.found_payload = deque_payloads[pos];
            if (drop) begin
               deque_keys.delete(pos);
               deque_payloads.delete(pos);
            end
         end else begin
            res.status = STS_NONE;
         end
      end
      res.entry_count = 5'(deque_keys.size());
      return res;
   endfunction

   // Keys mostly from a small pool so searches hit and minimums tie
   function automatic logic signed [31:0] pick_key();
      logic signed [31:0] pool[8];
      pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0,
               32'sd1, 32'sd5, -32'sd7, 32'sd100};
      if ($urandom_range(0, 9) < 7)
         return pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_payload();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(input logic [3:0] op, input logic signed [31:0] key,
                           input logic [31:0] payload, input int unsigned gap,
                           input bit drain);
      op_slot_type s;
      s.req.opcode  = op;
      s.req.key     = key;
      s.req.payload = payload;
      s.gap         = gap;
      s.drain       = drain;
      op_slots.push_back(s);
   endtask

   // Present queued items; keep start high across back-to-back items
   always @(posedge clock) begin
      logic launch;
      launch = 1'b0;
      if (reset) begin
         start       <= 1'b0;
         req_data    <= '0;
         idle_cycles <= 0;
      end else if (start && busy) begin
         // hold the item until the core takes it
      end else begin
         if (op_slots.size() != 0) begin
            if (start)
               launch = (op_slots[0].gap == 0) && !op_slots[0].drain;
            else
               launch = (idle_cycles >= op_slots[0].gap) &&
                        (!op_slots[0].drain || (outstanding == 0 && !busy));
         end
         if (launch) begin
            req_data    <= op_slots[0].req;
            start       <= 1'b1;
            idle_cycles <= 0;
            void'(op_slots.pop_front());
         end else begin
            start       <= 1'b0;
            idle_cycles <= start ? 0 : idle_cycles + 1;
         end
      end
   end

   // Check strobed responses, then predict for the item taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      logic    took;
      logic    gave;
      took = start && !busy;
      gave = rsp_strobe;
      if (reset) begin
         outstanding <= 0;
      end else begin
         if (gave) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with no item pending");
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.found_key !== want.found_key)
                  report_mismatch($sformatf("found_key %h, want %h",
                                            rsp_data.found_key, want.found_key));
               if (rsp_data.found_payload !== want.found_payload)
                  report_mismatch($sformatf("found_payload %h, want %h",
                                            rsp_data.found_payload, want.found_payload));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count %0d, want %0d",
                                            rsp_data.entry_count, want.entry_count));
            end
         end
         if (took)
            expected_rsp.push_back(apply_op(req_data));
         outstanding <= outstanding + int'(took) - int'(gave);
      end
   end

   // Build the item list, then wait for the core to drain
   initial begin
      int unsigned push_pct;
      int unsigned phase_left;
      int unsigned roll;
      bit          quiet;
      logic [3:0]  op;

      // empty-store cases and unused opcodes
      add_item(OP_POP_FRONT,  32'sd0, 32'h0, 0, 0);
      add_item(OP_POP_BACK,   32'sd0, 32'h0, 1, 0);
      add_item(OP_PEEK_FRONT, 32'sd0, 32'h0, 0, 0);
      add_item(OP_PEEK_BACK,  32'sd0, 32'h0, 2, 0);
      add_item(OP_FIND_KEY,   32'sd0, 32'h0, 0, 0);
      add_item(OP_REMOVE_KEY, 32'sd0, 32'h0, 3, 0);
      add_item(OP_FIND_MIN,   32'sd0, 32'h0, 0, 0);
      add_item(OP_REMOVE_MIN, 32'sd0, 32'h0, 0, 0);
      add_item(4'd10, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1, 0);
      add_item(4'd15, 32'sh8000_0000, 32'h0, 0, 0);
      // extremes, a tie on the minimum, hits and a miss
      add_item(OP_PUSH_BACK,  32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
      add_item(OP_PUSH_FRONT, 32'sh8000_0000, 32'h0000_0000, 0, 0);
      add_item(OP_PUSH_BACK,  32'sd5,         32'h0000_0001, 2, 0);
      add_item(OP_PUSH_FRONT, 32'sh8000_0000, 32'h0000_0002, 0, 0);
      add_item(OP_PEEK_FRONT, 32'sd0, 32'h0, 0, 0);
      add_item(OP_PEEK_BACK,  32'sd0, 32'h0, 0, 0);
      add_item(OP_FIND_MIN,   32'sd0, 32'h0, 1, 0);
      add_item(OP_FIND_KEY,   32'sd5, 32'h0, 0, 0);
      add_item(OP_FIND_KEY,   32'sd3, 32'h0, 0, 0);
      add_item(OP_REMOVE_MIN, 32'sd0, 32'h0, 0, 0);
      add_item(OP_REMOVE_KEY, 32'sh7FFF_FFFF, 32'h0, 3, 0);
      add_item(OP_POP_BACK,   32'sd0, 32'h0, 0, 0);
      add_item(OP_POP_FRONT,  32'sd0, 32'h0, 0, 0);
      add_item(OP_POP_FRONT,  32'sd0, 32'h0, 0, 0);
      add_item(4'd12, -32'sd1, 32'h1234_5678, 0, 0);

      // random phases, each with its own push mix and idling
      push_pct   = 0;
      phase_left = 0;
      quiet      = 0;
      for (int n = 0; n < ITEM_TARGET; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            push_pct   = 10 + 20 * $urandom_range(0, 4);
            quiet      = ($urandom_range(0, 3) == 0);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else if (roll < push_pct + 3)
            op = 4'($urandom_range(10, 15));
         else
            op = 4'($urandom_range(OP_POP_FRONT, OP_REMOVE_MIN));
         add_item(op, pick_key(), pick_payload(),
                  quiet ? 0 : $urandom_range(0, 3), (n % 250) == 125);
      end

      do @(negedge clock);
      while (op_slots.size() != 0 || start || outstanding != 0);
      repeat (DEPTH + 6) @(negedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
sv/kdq_pkg.sv
sv/kdq_cell.sv
sv/keyed_deque_with_min_extract_core.sv
verif/tb_top.sv
